// ----- rtl/sdb_pkg.sv -----
// Package with payload types and constants for the scaled delta blit unit.
`default_nettype none
package sdb_pkg;
	localparam int FracBits = 16;
	localparam int DeltaLimit = 12;
	localparam int StepW = 28;
	localparam int AccW = 29;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_SRC_W  = 3'd0,
		REG_SRC_H  = 3'd1,
		REG_LEFT   = 3'd2,
		REG_TOP    = 3'd3,
		REG_TGT_W  = 3'd4,
		REG_TGT_H  = 3'd5,
		REG_SCR_W  = 3'd6,
		REG_SCR_H  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        frame_is_first;
		logic [7:0]  src_blue;
		logic [7:0]  src_green;
		logic [7:0]  src_red;
		logic [23:0] screen_color;
	} in_item_t;

	typedef struct packed {
		logic        write_enable;
		logic [23:0] write_color;
		logic [11:0] fetch_src_x;
		logic [11:0] fetch_src_y;
		logic [11:0] fetch_screen_x;
		logic [11:0] fetch_screen_y;
		logic        frame_done;
		logic        dirty_valid;
		logic [11:0] dirty_x;
		logic [11:0] dirty_y;
		logic [12:0] dirty_w;
		logic [12:0] dirty_h;
	} out_item_t;
endpackage
`default_nettype wire

// ----- rtl/sdb_divider.sv -----
// Restoring divider that forms a 12.16 step size one quotient bit per cycle.
`default_nettype none
module sdb_divider
	import sdb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [11:0]      dividend,
	input  wire logic [11:0]      divisor,
	output logic                  busy,
	output logic [StepW-1:0]      quotient
);
	logic [4:0]  count_q;
	logic [StepW-1:0] num_q;
	logic [12:0] rem_q;
	logic [11:0] div_q;
	logic [12:0] trial;
	logic [13:0] diff;

	always_comb begin
		trial = {rem_q[11:0], num_q[StepW-1]};
		diff = {1'b0, trial} - {2'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			busy <= 1'b1;
			count_q <= 5'(StepW - 1);
		end else if (busy) begin
			if (count_q == '0) busy <= 1'b0;
			else count_q <= count_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, {FracBits{1'b0}}};
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			if (!diff[13]) begin
				rem_q <= diff[12:0];
				num_q <= {num_q[StepW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[StepW-2:0], 1'b0};
			end
		end
	end
	assign quotient = num_q;
endmodule
`default_nettype wire

// ----- rtl/scaled_delta_blit_unit.sv -----
// Top level of the scaled delta blit unit: sequencer, pixel datapath and result register.
// A pixel transaction in an active frame passes from idle through the pixel state to the
// output state, where its result is held until taken; only then is the next one accepted.
// A start transaction runs two serial divisions, then steps once per skipped column and row
// before its result is shown. An empty start goes straight to the output state.
// Reset clears all control state, the cache flag and the result valid.
`default_nettype none
module scaled_delta_blit_unit
	import sdb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [12:0] cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_DIVH, ST_DIVV, ST_SKIPX, ST_SKIPY, ST_PIXEL, ST_OUT
	} state_t;

	state_t state_q;
	logic [11:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic signed [12:0] left_q, top_q;
	logic [12:0] scr_w_q, scr_h_q;

	logic drawn_q, redraw_q, active_q, written_q;
	logic [StepW-1:0] step_h_q, step_v_q;
	logic [AccW-1:0] acc_h_q, acc_v_q, acc_h0_q;
	logic signed [14:0] col_q, row_q, cw_q, ch_q, first_col_q, skip_q;
	logic signed [14:0] bx0_q, by0_q, bx1_q, by1_q, hleft_q, htop_q;
	logic [11:0] hsw_q, hsh_q;
	in_item_t pix_q;

	logic div_start, div_busy;
	logic [11:0] div_a, div_b;
	logic [StepW-1:0] div_q;

	sdb_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	// Start transaction clipping.
	logic signed [14:0] sl, st, sdw, sdh, fc, fr;
	logic empty_a, empty_b;
	always_comb begin
		sl = 15'(left_q);
		st = 15'(top_q);
		sdw = 15'(signed'({1'b0, tgt_w_q}));
		sdh = 15'(signed'({1'b0, tgt_h_q}));
		if (sl + sdw > 15'(signed'({1'b0, scr_w_q}))) sdw = 15'(signed'({1'b0, scr_w_q})) - sl;
		if (st + sdh > 15'(signed'({1'b0, scr_h_q}))) sdh = 15'(signed'({1'b0, scr_h_q})) - st;
		fc = (sl < 0) ? -sl : 15'sd0;
		fr = (st < 0) ? -st : 15'sd0;
		empty_a = tgt_w_q == '0 || tgt_h_q == '0 || src_w_q == '0 || src_h_q == '0
			|| sl >= 15'(signed'({1'b0, scr_w_q})) || st >= 15'(signed'({1'b0, scr_h_q}))
			|| sdw <= 0 || sdh <= 0;
		empty_b = fc >= sdw || fr >= sdh;
	end

	// Pixel delta.
	logic [8:0] dr, dg, db;
	logic [9:0] dsum;
	logic we;
	logic signed [14:0] px, py;
	always_comb begin
		dr = (pix_q.src_red > pix_q.screen_color[23:16]) ?
			9'(pix_q.src_red - pix_q.screen_color[23:16]) :
			9'(pix_q.screen_color[23:16] - pix_q.src_red);
		dg = (pix_q.src_green > pix_q.screen_color[15:8]) ?
			9'(pix_q.src_green - pix_q.screen_color[15:8]) :
			9'(pix_q.screen_color[15:8] - pix_q.src_green);
		db = (pix_q.src_blue > pix_q.screen_color[7:0]) ?
			9'(pix_q.src_blue - pix_q.screen_color[7:0]) :
			9'(pix_q.screen_color[7:0] - pix_q.src_blue);
		dsum = 10'(dr) + 10'(dg) + 10'(db);
		we = redraw_q || (dsum > 10'(DeltaLimit));
		px = hleft_q + col_q;
		py = htop_q + row_q;
	end

	function automatic logic [11:0] clamp_src(input logic [AccW-1:0] acc, input logic [11:0] lim);
		logic [12:0] v;
		v = acc[AccW-1:FracBits];
		return (v >= 13'(lim)) ? 12'(lim - 12'd1) : v[11:0];
	endfunction

	function automatic out_item_t frame_end_item();
		out_item_t r;
		r = '0;
		r.frame_done = 1'b1;
		return r;
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign div_start = (state_q == ST_DIVH && !div_busy && skip_q == 15'sd1)
		|| (state_q == ST_DIVV && !div_busy && skip_q == 15'sd1);
	assign div_a = (state_q == ST_DIVH) ? src_w_q : src_h_q;
	assign div_b = (state_q == ST_DIVH) ? tgt_w_q : tgt_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_w_q <= '0; src_h_q <= '0; tgt_w_q <= '0; tgt_h_q <= '0;
			left_q <= '0; top_q <= '0; scr_w_q <= '0; scr_h_q <= '0;
			drawn_q <= 1'b0; redraw_q <= 1'b0; active_q <= 1'b0; written_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
			pix_q <= '0;
			skip_q <= '0;
			step_h_q <= '0; step_v_q <= '0;
			acc_h_q <= '0; acc_v_q <= '0; acc_h0_q <= '0;
			col_q <= '0; row_q <= '0; cw_q <= '0; ch_q <= '0; first_col_q <= '0;
			bx0_q <= 15'sd1; by0_q <= 15'sd1; bx1_q <= '0; by1_q <= '0;
			hleft_q <= '0; htop_q <= '0;
			hsw_q <= 12'd1; hsh_q <= 12'd1;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SRC_W: src_w_q <= cfg_data[11:0];
					REG_SRC_H: src_h_q <= cfg_data[11:0];
					REG_LEFT:  left_q <= cfg_data;
					REG_TOP:   top_q <= cfg_data;
					REG_TGT_W: tgt_w_q <= cfg_data[11:0];
					REG_TGT_H: tgt_h_q <= cfg_data[11:0];
					REG_SCR_W: scr_w_q <= cfg_data;
					REG_SCR_H: scr_h_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pix_q <= in_data;
						case (mode_t'(in_data.mode))
							MODE_START: begin
								active_q <= 1'b0;
								written_q <= 1'b0;
								if (empty_a) begin
									out_data <= frame_end_item();
									state_q <= ST_OUT;
								end else begin
									redraw_q <= !drawn_q || in_data.frame_is_first;
									drawn_q <= 1'b1;
									hleft_q <= sl; htop_q <= st;
									hsw_q <= src_w_q; hsh_q <= src_h_q;
									cw_q <= sdw; ch_q <= sdh;
									bx0_q <= sl + sdw; by0_q <= st + sdh;
									bx1_q <= sl; by1_q <= st;
									first_col_q <= fc;
									col_q <= fc; row_q <= fr;
									if (empty_b) begin
										out_data <= frame_end_item();
										state_q <= ST_OUT;
									end else begin
										skip_q <= 15'sd1;
										state_q <= ST_DIVH;
									end
								end
							end
							MODE_PIXEL: if (active_q) state_q <= ST_PIXEL;
							MODE_CLEAR: drawn_q <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_DIVH: begin
					if (skip_q == 15'sd1) skip_q <= 15'sd0;
					else if (!div_busy) begin
						step_h_q <= div_q;
						skip_q <= 15'sd1;
						state_q <= ST_DIVV;
					end
				end
				ST_DIVV: begin
					if (skip_q == 15'sd1) skip_q <= 15'sd0;
					else if (!div_busy) begin
						step_v_q <= div_q;
						acc_h_q <= '0; acc_v_q <= '0;
						skip_q <= first_col_q;
						state_q <= ST_SKIPX;
					end
				end
				ST_SKIPX: begin
					if (skip_q == 15'sd0) begin
						acc_h0_q <= acc_h_q;
						skip_q <= row_q;
						state_q <= ST_SKIPY;
					end else begin
						acc_h_q <= acc_h_q + AccW'(step_h_q);
						skip_q <= skip_q - 15'sd1;
					end
				end
				ST_SKIPY: begin
					out_item_t res;
					res = '0;
					res.fetch_src_x = clamp_src(acc_h_q, hsw_q);
					res.fetch_src_y = clamp_src(acc_v_q, hsh_q);
					res.fetch_screen_x = px[11:0];
					res.fetch_screen_y = py[11:0];
					if (skip_q == 15'sd0) begin
						active_q <= 1'b1;
						out_data <= res;
						state_q <= ST_OUT;
					end else begin
						acc_v_q <= acc_v_q + AccW'(step_v_q);
						skip_q <= skip_q - 15'sd1;
					end
				end
				ST_PIXEL: begin
					logic signed [14:0] nb0, nb1, nb2, nb3, ncol, nrow;
					logic [AccW-1:0] nah, nav;
					logic done, nw;
					out_item_t res;
					nb0 = bx0_q; nb1 = by0_q; nb2 = bx1_q; nb3 = by1_q;
					nw = written_q;
					if (we) begin
						nw = 1'b1;
						if (px < nb0) nb0 = px;
						if (px > nb2) nb2 = px;
						if (py < nb1) nb1 = py;
						if (py > nb3) nb3 = py;
					end
					ncol = col_q + 15'sd1; nrow = row_q;
					nah = acc_h_q + AccW'(step_h_q); nav = acc_v_q;
					done = 1'b0;
					if (ncol >= cw_q) begin
						nrow = row_q + 15'sd1;
						nav = acc_v_q + AccW'(step_v_q);
						if (nrow >= ch_q) done = 1'b1;
						else begin
							ncol = first_col_q;
							nah = acc_h0_q;
						end
					end
					res = '0;
					res.write_enable = we;
					res.write_color = {pix_q.src_red, pix_q.src_green, pix_q.src_blue};
					if (done) begin
						res.frame_done = 1'b1;
						if (nw) begin
							res.dirty_valid = 1'b1;
							res.dirty_x = nb0[11:0];
							res.dirty_y = nb1[11:0];
							res.dirty_w = 13'(nb2 - nb0 + 15'sd1);
							res.dirty_h = 13'(nb3 - nb1 + 15'sd1);
						end
					end else begin
						res.fetch_src_x = clamp_src(nah, hsw_q);
						res.fetch_src_y = clamp_src(nav, hsh_q);
						res.fetch_screen_x = 12'(hleft_q + ncol);
						res.fetch_screen_y = 12'(htop_q + nrow);
					end
					written_q <= nw;
					bx0_q <= nb0; by0_q <= nb1; bx1_q <= nb2; by1_q <= nb3;
					col_q <= ncol; row_q <= nrow; acc_h_q <= nah; acc_v_q <= nav;
					if (done) active_q <= 1'b0;
					out_data <= res;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == ST_OUT)
		else $error("result valid outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> !active_q)
		else $error("frame still active on final result");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.dirty_valid |-> out_data.frame_done)
		else $error("dirty box without frame end");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIXEL) |-> active_q)
		else $error("pixel processed while idle");
endmodule
`default_nettype wire
